### src/pfd_pkg.sv
// Shared types and constants of the PPM frame decoder.
package pfd_pkg;

  localparam int CHANNELS_DEF = 8;

  localparam int STAMP_W = 16;
  localparam int WIDTH_W = 15;
  localparam int IDX_W   = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [STAMP_W-1:0] WRAP_RESET = 16'd40000;
  localparam logic [STAMP_W-1:0] SYNC_RESET = 16'd8000;
  localparam logic [WIDTH_W-1:0] MIN_RESET  = 15'd900;
  localparam logic [WIDTH_W-1:0] MAX_RESET  = 15'd2100;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WRAP_PERIOD = 2'd0,
    CFG_SYNC_GAP    = 2'd1,
    CFG_MIN_WIDTH   = 2'd2,
    CFG_MAX_WIDTH   = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    REQ_CAPTURE = 1'b0,
    REQ_READ    = 1'b1
  } req_t;

  // Per-item info handed from the issue stage to the result stage
  typedef struct packed {
    logic is_read;
    logic rd_zero;
    logic ready_before;
  } issue_t;

endpackage

### src/pfd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pfd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8,
  parameter int AW    = 3
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### src/pfd_capture.sv
// Issue stage: interval from timestamps, slot counter, frame flag and store access.
module pfd_capture import pfd_pkg::*; #(
  parameter int CHANNELS = CHANNELS_DEF,
  parameter int AW       = 3,
  parameter int SW       = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  logic               req_type,
  input  logic [STAMP_W-1:0] capture_time,
  input  logic [IDX_W-1:0]   channel_index,
  input  logic [STAMP_W-1:0] wrap_period,
  input  logic [STAMP_W-1:0] sync_gap,
  output logic               ram_we,
  output logic [AW-1:0]      ram_waddr,
  output logic [STAMP_W-1:0] ram_wdata,
  output logic               ram_re,
  output logic [AW-1:0]      ram_raddr,
  output issue_t             issue
);

  localparam logic [SW-1:0] SLOT_FULL = SW'(CHANNELS);
  localparam logic [IDX_W:0] IDX_LIMIT = (IDX_W+1)'(CHANNELS);

  logic [STAMP_W-1:0]  prev_time_r, prev_time_nxt;
  logic [SW-1:0]       slot_r, slot_nxt;
  logic                ready_r, ready_nxt;
  logic [CHANNELS-1:0] written_r, written_nxt;

  logic [STAMP_W-1:0] interval;
  logic               is_capture;
  logic               is_sync;
  logic               slot_free;
  logic               idx_in_range;
  logic [AW-1:0]      rd_addr;

  assign is_capture   = (req_type == REQ_CAPTURE);
  assign interval     = (capture_time < prev_time_r)
                        ? (capture_time + wrap_period - prev_time_r)
                        : (capture_time - prev_time_r);
  assign is_sync      = (interval > sync_gap);
  assign slot_free    = (slot_r < SLOT_FULL);
  assign idx_in_range = ({1'b0, channel_index} < IDX_LIMIT);
  assign rd_addr      = AW'(channel_index);

  assign ram_we    = accept && is_capture && !is_sync && slot_free;
  assign ram_waddr = AW'(slot_r);
  assign ram_wdata = interval;
  assign ram_re    = accept && !is_capture && idx_in_range;
  assign ram_raddr = rd_addr;

  // Entries never written since reset read as zero
  assign issue.is_read      = !is_capture;
  assign issue.rd_zero      = !idx_in_range || !written_r[rd_addr];
  assign issue.ready_before = ready_r;

  always_comb begin
    prev_time_nxt = prev_time_r;
    slot_nxt      = slot_r;
    ready_nxt     = ready_r;
    written_nxt   = written_r;
    if (accept) begin
      if (is_capture) begin
        prev_time_nxt = capture_time;
        if (is_sync) begin
          slot_nxt = '0;
        end else if (slot_free) begin
          slot_nxt = slot_r + 1'b1;
          written_nxt[ram_waddr] = 1'b1;
          if (slot_nxt >= SLOT_FULL) begin
            ready_nxt = 1'b1;
          end
        end
      end else begin
        ready_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_time_r <= '0;
      slot_r      <= '0;
      ready_r     <= 1'b0;
      written_r   <= '0;
    end else begin
      prev_time_r <= prev_time_nxt;
      slot_r      <= slot_nxt;
      ready_r     <= ready_nxt;
      written_r   <= written_nxt;
    end
  end

endmodule

### src/pfd_out.sv
// Result stage: clamp of the stored width and the output register.
module pfd_out import pfd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  issue_t             issue,
  input  logic [STAMP_W-1:0] ram_rdata,
  input  logic [WIDTH_W-1:0] min_width,
  input  logic [WIDTH_W-1:0] max_width,
  output logic               stage_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [WIDTH_W-1:0] out_width,
  output logic               out_frame_ready
);

  logic               s1_valid_r, s1_valid_nxt;
  issue_t             s1_info_r;
  logic               out_valid_r, out_valid_nxt;
  logic [WIDTH_W-1:0] out_width_r;
  logic               out_frame_r;

  logic               s1_adv;
  logic [WIDTH_W-1:0] halved;
  logic [WIDTH_W-1:0] clamped;

  assign s1_adv      = s1_valid_r && (!out_valid_r || out_ready);
  assign stage_ready = !s1_valid_r || !out_valid_r || out_ready;

  // Store holds ticks at twice the resolution of microseconds
  assign halved = s1_info_r.rd_zero ? '0 : ram_rdata[STAMP_W-1:1];

  always_comb begin
    if (!s1_info_r.is_read) begin
      clamped = '0;
    end else if (halved < min_width) begin
      clamped = min_width;
    end else if (halved > max_width) begin
      clamped = max_width;
    end else begin
      clamped = halved;
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_info_r <= issue;
    end
    if (s1_adv) begin
      out_width_r <= clamped;
      out_frame_r <= s1_info_r.ready_before;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_width       = out_width_r;
  assign out_frame_ready = out_frame_r;

endmodule

### src/ppm_frame_decoder_core.sv
// Top level of the PPM frame decoder: configuration registers and stage wiring.
//
// Decodes an RC PPM pulse train. A capture item (req_type 0) carries a timer
// stamp; the interval to the previous stamp, corrected for the timer wrap,
// either restarts the frame (above the sync gap) or fills the next channel
// slot, and the frame-ready flag rises once all CHANNELS slots are filled.
// A read item (req_type 1) returns the stored width of one channel halved
// and clamped to [min, max], and clears the flag. Every item gives one
// result; frame_ready shows the flag as it was before that item. The block
// accepts one item per clock unless a stalled output fills both stages; a
// result passes through the channel store's registered read and then the
// output register. The store is usable right after reset (per-slot written
// bits). Configuration writes are always accepted and must only be made
// while no item is in flight.
module ppm_frame_decoder_core import pfd_pkg::*; #(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_req_type,
  input  logic [STAMP_W-1:0]    in_capture_time,
  input  logic [IDX_W-1:0]      in_channel_index,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [WIDTH_W-1:0]    out_channel_width_us,
  output logic                  out_frame_ready,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SW = $clog2(CHANNELS + 1);

  logic [STAMP_W-1:0] wrap_r, wrap_nxt;
  logic [STAMP_W-1:0] sync_r, sync_nxt;
  logic [WIDTH_W-1:0] min_r, min_nxt;
  logic [WIDTH_W-1:0] max_r, max_nxt;

  logic               accept;
  logic               stage_ready;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [STAMP_W-1:0] ram_wdata;
  logic               ram_re;
  logic [AW-1:0]      ram_raddr;
  logic [STAMP_W-1:0] ram_rdata;
  issue_t             issue;

  assign cfg_ready = 1'b1;
  assign in_ready  = stage_ready;
  assign accept    = in_valid && stage_ready;

  always_comb begin
    wrap_nxt = wrap_r;
    sync_nxt = sync_r;
    min_nxt  = min_r;
    max_nxt  = max_r;
    if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        CFG_WRAP_PERIOD: wrap_nxt = cfg_data;
        CFG_SYNC_GAP:    sync_nxt = cfg_data;
        CFG_MIN_WIDTH:   min_nxt  = cfg_data[WIDTH_W-1:0];
        CFG_MAX_WIDTH:   max_nxt  = cfg_data[WIDTH_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wrap_r <= WRAP_RESET;
      sync_r <= SYNC_RESET;
      min_r  <= MIN_RESET;
      max_r  <= MAX_RESET;
    end else begin
      wrap_r <= wrap_nxt;
      sync_r <= sync_nxt;
      min_r  <= min_nxt;
      max_r  <= max_nxt;
    end
  end

  pfd_capture #(
    .CHANNELS (CHANNELS),
    .AW       (AW),
    .SW       (SW)
  ) u_capture (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .req_type      (in_req_type),
    .capture_time  (in_capture_time),
    .channel_index (in_channel_index),
    .wrap_period   (wrap_r),
    .sync_gap      (sync_r),
    .ram_we        (ram_we),
    .ram_waddr     (ram_waddr),
    .ram_wdata     (ram_wdata),
    .ram_re        (ram_re),
    .ram_raddr     (ram_raddr),
    .issue         (issue)
  );

  pfd_ram #(
    .WIDTH (STAMP_W),
    .DEPTH (CHANNELS),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  pfd_out u_out (
    .clk             (clk),
    .rst_n           (rst_n),
    .accept          (accept),
    .issue           (issue),
    .ram_rdata       (ram_rdata),
    .min_width       (min_r),
    .max_width       (max_r),
    .stage_ready     (stage_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_width       (out_channel_width_us),
    .out_frame_ready (out_frame_ready)
  );

endmodule

### src/pfd_checker.sv
// Port-level checks of the PPM frame decoder, bound to the top level.
module pfd_checker import pfd_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [WIDTH_W-1:0] out_channel_width_us,
  input logic               out_frame_ready
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_channel_width_us)
      && $stable(out_frame_ready))
    else $error("stalled result changed or dropped");

  // An empty output register never blocks the input side
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // Every accepted item shows a result on out_valid
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> ##2 out_valid)
    else $error("result missing two cycles after accept");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

endmodule

bind ppm_frame_decoder_core pfd_checker u_pfd_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_valid             (in_valid),
  .in_ready             (in_ready),
  .out_valid            (out_valid),
  .out_ready            (out_ready),
  .out_channel_width_us (out_channel_width_us),
  .out_frame_ready      (out_frame_ready)
);
